// File: src/isms_pkg.sv
// ----------------------------------------------------------------------------
// isms_pkg
// Shared constants, request and status codes, and types for the indexed stack
// with maximum scan.
// ----------------------------------------------------------------------------
package isms_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int REQ_W  = 3;
  localparam int ST_W   = 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((POS_W + 1) > CNT_W) ? (POS_W + 1) : CNT_W;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MAX    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic step;
    logic first;
  } max_ctrl_t;

endpackage

// File: src/isms_ram.sv
// ----------------------------------------------------------------------------
// isms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module isms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/isms_max_unit.sv
// ----------------------------------------------------------------------------
// isms_max_unit
// Shared signed compare unit holding the running maximum and its position.
// The first position of the maximum wins (strict greater-than).
// ----------------------------------------------------------------------------
module isms_max_unit
  import isms_pkg::*;
(
  input  logic                     clk_i,
  input  max_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [ADDR_W-1:0]        index_i,
  output logic signed [DATA_W-1:0] best_o,
  output logic [ADDR_W-1:0]        best_at_o
);

  logic signed [DATA_W-1:0] best_q;
  logic [ADDR_W-1:0]        best_at_q;
  logic                     take;

  assign take      = ctrl_i.first || (value_i > best_q);
  assign best_o    = take ? value_i : best_q;
  assign best_at_o = take ? index_i : best_at_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      best_q    <= best_o;
      best_at_q <= best_at_o;
    end
  end

endmodule

// File: src/indexed_stack_max_scan.sv
// ----------------------------------------------------------------------------
// indexed_stack_max_scan
// Stack of signed 32-bit entries with indexed overwrite, maximum scan and dump.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | req_type_i, position_i, data_in_i
//   out     | output    | out_valid_o / out_stall_i| status_o, data_out_o, where_o, last_o
//
// Append, write, error and unused requests: result in the cycle after accept.
// Pop: result after one RAM read, through the pop state and the output register.
// Max: one entry per cycle through the compare unit.
// Dump: one entry per cycle while out is not stalled; the output stall sets pace.
// Reset clears the state, count, index and output valid; entries are not cleared.
// in_stall_o is high while a request is in progress or the output is held.
// ----------------------------------------------------------------------------
module indexed_stack_max_scan
  import isms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [POS_W-1:0]         where_o,
  output logic                     last_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_MAX  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d, cnt_m1;
  logic [ADDR_W-1:0] idx_q, idx_d, last_idx;
  logic              out_valid_q, out_valid_d;
  logic              out_free, in_acc, full, empty, idx_last;

  logic                     ld;
  logic [ST_W-1:0]          ld_status;
  logic signed [DATA_W-1:0] ld_data;
  logic [ADDR_W-1:0]        ld_where;
  logic                     ld_last;

  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic signed [DATA_W-1:0] rdata;

  max_ctrl_t                max_ctrl;
  logic signed [DATA_W-1:0] best;
  logic [ADDR_W-1:0]        best_at;

  logic [ST_W-1:0]          status_q;
  logic signed [DATA_W-1:0] data_q;
  logic [ADDR_W-1:0]        where_q;
  logic                     last_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign cnt_m1     = count_q - CNT_W'(1);
  assign last_idx   = cnt_m1[ADDR_W-1:0];
  assign idx_last   = (idx_q == last_idx);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    ld        = 1'b0;
    ld_status = ST_OK;
    ld_data   = '0;
    ld_where  = '0;
    ld_last   = 1'b1;
    we        = 1'b0;
    waddr     = count_q[ADDR_W-1:0];
    max_ctrl  = '{step: 1'b0, first: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ld = 1'b1;
          unique case (req_type_i)
            REQ_APPEND: begin
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            REQ_POP: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                ld      = 1'b0;
                count_d = cnt_m1;
                idx_d   = last_idx;
                state_d = S_POP;
              end
            end
            REQ_WRITE: begin
              if (CMP_W'(position_i) >= CMP_W'(count_q)) begin
                ld_status = ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = position_i[ADDR_W-1:0];
              end
            end
            REQ_MAX, REQ_DUMP: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                ld      = 1'b0;
                idx_d   = '0;
                state_d = (req_type_i == REQ_MAX) ? S_MAX : S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        ld       = 1'b1;
        ld_data  = rdata;
        ld_where = idx_q;
        state_d  = S_IDLE;
      end
      S_MAX: begin
        max_ctrl = '{step: 1'b1, first: (idx_q == '0)};
        if (idx_last) begin
          ld       = 1'b1;
          ld_data  = best;
          ld_where = best_at;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_q + ADDR_W'(1);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_data  = rdata;
          ld_where = idx_q;
          ld_last  = idx_last;
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + ADDR_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = ld ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      status_q <= ld_status;
      data_q   <= ld_data;
      where_q  <= ld_where;
      last_q   <= ld_last;
    end
  end

  // read address follows the next index so read data matches idx_q
  isms_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(data_in_i),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  isms_max_unit u_max (
    .clk_i    (clk_i),
    .ctrl_i   (max_ctrl),
    .value_i  (rdata),
    .index_i  (idx_q),
    .best_o   (best),
    .best_at_o(best_at)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign where_o     = POS_W'(where_q);
  assign last_o      = last_q;

  a_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == S_IDLE)
    else $error("request taken while busy");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == REQ_APPEND && !full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not advance count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == REQ_POP && !empty |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not reduce count");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP && out_free && idx_last |=> state_q == S_IDLE && out_valid_o && last_o)
    else $error("dump did not end on last entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> count_q <= CNT_W'(DEPTH))
    else $error("count beyond depth");

endmodule

// File: bench/indexed_stack_max_scan_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_stack_max_scan_tb
// Pushes directed and random requests through the stack with max scan. A shadow
// copy of the stack predicts every result, and the output side is checked in order.
// Both sides idle at random in two phases with swapped rates, then not at all.
// ----------------------------------------------------------------------------

import isms_pkg::*;

typedef struct {
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         where;
  logic                     last;
} scan_result_t;

class stack_mirror;
  const int unsigned report_max = 10;

  logic signed [DATA_W-1:0] slots [DEPTH];
  int unsigned              fill;
  scan_result_t             awaited [$];
  int unsigned              mismatches;

  function new();
    fill = 0;
    mismatches = 0;
  endfunction

  function void flag(string note);
    mismatches++;
    if (mismatches <= report_max) $display("ERROR: %s", note);
  endfunction

  function void push(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] v,
                     logic [POS_W-1:0] at, logic fin);
    scan_result_t r;
    r.status = st;
    r.value  = v;
    r.where  = at;
    r.last   = fin;
    awaited.push_back(r);
  endfunction

  function void note_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] value);
    logic signed [DATA_W-1:0] best;
    int unsigned              best_at;
    case (kind)
      REQ_APPEND: begin
        if (fill >= DEPTH) begin
          push(ST_FULL, '0, '0, 1'b1);
        end else begin
          slots[fill] = value;
          fill++;
          push(ST_OK, '0, '0, 1'b1);
        end
      end
      REQ_POP: begin
        if (fill == 0) begin
          push(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          fill--;
          push(ST_OK, slots[fill], POS_W'(fill), 1'b1);
        end
      end
      REQ_WRITE: begin
        if (pos >= fill) begin
          push(ST_RANGE, '0, '0, 1'b1);
        end else begin
          slots[pos] = value;
          push(ST_OK, '0, '0, 1'b1);
        end
      end
      REQ_MAX: begin
        if (fill == 0) begin
          push(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          best = slots[0];
          best_at = 0;
          for (int unsigned i = 1; i < fill; i++) begin
            if (slots[i] > best) begin
              best = slots[i];
              best_at = i;
            end
          end
          push(ST_OK, best, POS_W'(best_at), 1'b1);
        end
      end
      REQ_DUMP: begin
        if (fill == 0) begin
          push(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++) begin
            push(ST_OK, slots[i], POS_W'(i), (i + 1 == fill));
          end
        end
      end
      default: push(ST_OK, '0, '0, 1'b1);
    endcase
  endfunction

  function void check_result(scan_result_t got);
    scan_result_t want;
    if (awaited.size() == 0) begin
      flag($sformatf("unexpected result: status %0d data %0d where %0d last %0d",
                     got.status, got.value, got.where, got.last));
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status || got.value !== want.value ||
        got.where !== want.where || got.last !== want.last) begin
      flag($sformatf({"expected status %0d data %0d where %0d last %0d, ",
                      "got status %0d data %0d where %0d last %0d"},
                     want.status, want.value, want.where, want.last,
                     got.status, got.value, got.where, got.last));
    end
  endfunction

  function void finish_check();
    if (awaited.size() != 0) flag($sformatf("%0d results never arrived", awaited.size()));
  endfunction
endclass

module indexed_stack_max_scan_tb;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 2 * DEPTH + 16;
  localparam int ITEMS_PER_PHASE = 140;

  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic [REQ_W-1:0]         req_type_i  = REQ_APPEND;
  logic [POS_W-1:0]         position_i  = '0;
  logic signed [DATA_W-1:0] data_in_i   = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [ST_W-1:0]          status_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [POS_W-1:0]         where_o;
  logic                     last_o;

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  stack_mirror mirror;

  indexed_stack_max_scan DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .where_o     (where_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    scan_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.status = status_o;
      seen.value  = data_out_o;
      seen.where  = where_o;
      seen.last   = last_o;
      mirror.check_result(seen);
    end
  end

  task automatic send_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    position_i <= pos;
    data_in_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(kind, pos, value);
    if (kind <= REQ_DUMP) requests_sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return DATA_W'($urandom_range(6)) - DATA_W'(3);  // small values make ties
      default: return $urandom();
    endcase
  endfunction

  task automatic send_mixed();
    int unsigned      roll;
    logic [POS_W-1:0] pos;
    logic [REQ_W-1:0] kind;
    roll = $urandom_range(99);
    pos = POS_W'($urandom());
    if (mirror.fill > 0 && $urandom_range(3) != 0) pos = POS_W'($urandom_range(mirror.fill - 1));
    if (roll < 30)      kind = REQ_APPEND;
    else if (roll < 47) kind = REQ_POP;
    else if (roll < 67) kind = REQ_WRITE;
    else if (roll < 83) kind = REQ_MAX;
    else if (roll < 95) kind = REQ_DUMP;
    else begin
      case ($urandom_range(2))
        0:       kind = REQ_SPARE_A;
        1:       kind = REQ_SPARE_B;
        default: kind = REQ_SPARE_C;
      endcase
    end
    send_request(kind, pos, pick_value());
  endtask

  task automatic run_directed();
    send_request(REQ_POP,    '0, '0);
    send_request(REQ_MAX,    '0, '0);
    send_request(REQ_DUMP,   '0, '0);
    send_request(REQ_WRITE,  '0, VAL_MAX);
    send_request(REQ_APPEND, '0, VAL_MIN);
    send_request(REQ_APPEND, '0, VAL_MAX);
    send_request(REQ_APPEND, '0, VAL_MAX);
    send_request(REQ_APPEND, '0, -1);
    send_request(REQ_MAX,    '0, '0);
    send_request(REQ_WRITE,  POS_W'(3), VAL_MAX);
    send_request(REQ_WRITE,  '0, VAL_MAX);
    send_request(REQ_MAX,    '0, '0);
    send_request(REQ_WRITE,  POS_W'(4), 1);
    send_request(REQ_WRITE,  '1, '1);
    send_request(REQ_DUMP,   '0, '0);
    send_request(REQ_SPARE_A, '1, '1);
    send_request(REQ_SPARE_B, '0, VAL_MIN);
    send_request(REQ_SPARE_C, '1, VAL_MAX);
    repeat (5) send_request(REQ_POP, '0, '0);
    send_request(REQ_APPEND, '0, '0);
    send_request(REQ_MAX,    '0, '0);
  endtask

  // cycles through mixed traffic, fill past full and a max, mixed traffic, drain past empty
  task automatic run_phase(int unsigned goal);
    int unsigned episode;
    episode = 0;
    while (requests_sent < goal) begin
      case (episode % 4)
        1: begin
          while (mirror.fill < DEPTH) send_request(REQ_APPEND, POS_W'($urandom()), pick_value());
          repeat ($urandom_range(2, 1)) send_request(REQ_APPEND, POS_W'($urandom()), pick_value());
          send_request(REQ_MAX, POS_W'($urandom()), pick_value());
        end
        3: begin
          while (mirror.fill > 0) send_request(REQ_POP, POS_W'($urandom()), pick_value());
          send_request(REQ_POP, POS_W'($urandom()), pick_value());
        end
        default: begin
          repeat ($urandom_range(30, 10)) send_mixed();
        end
      endcase
      episode++;
    end
  endtask

  initial begin
    mirror = new();
    tx_idle_pct = 16;
    rx_idle_pct = 60;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_phase(ITEMS_PER_PHASE);
    tx_idle_pct = 60;
    rx_idle_pct = 16;
    run_phase(2 * ITEMS_PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(3 * ITEMS_PER_PHASE);
    in_valid_i <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mirror.finish_check();
    if (mirror.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/isms_pkg.sv
src/isms_ram.sv
src/isms_max_unit.sv
src/indexed_stack_max_scan.sv
bench/indexed_stack_max_scan_tb.sv
